// ----- rtl/core/fta_pkg.sv -----
// Package for the fine-tune acceleration and clamp block.
// Holds widths, limits, register indexes, mode codes and the configuration struct.
// No dependencies.
package fta_pkg;

  localparam int NUM_VFOS = 2;
  localparam int VFO_W    = (NUM_VFOS > 1) ? $clog2(NUM_VFOS) : 1;

  localparam int RATE_W   = 18;
  localparam int ZOOM_W   = 3;
  localparam int MODE_W   = 2;
  localparam int LOCUT_W  = 16;
  localparam int HICUT_W  = 15;
  localparam int STEP_W   = 17;
  localparam int DELTA_W  = 8;
  localparam int TIME_W   = 32;
  localparam int OFF_W    = 18;
  localparam int CFG_W    = 18;
  localparam int IDX_W    = 3;
  localparam int CNT_W    = 3;
  localparam int PROD_W   = STEP_W + 1 + DELTA_W;
  localparam int WIDE_W   = 28;

  localparam logic [TIME_W-1:0] FAST_CANCEL_MS = TIME_W'(500);
  localparam logic [TIME_W-1:0] FAST_GAP_MS    = TIME_W'(100);
  localparam logic [CNT_W-1:0]  FAST_TRIGGER   = CNT_W'(4);
  localparam logic [STEP_W-1:0] FAST_STEP_HZ   = STEP_W'(1000);

  localparam logic signed [WIDE_W-1:0] OFFSET_MAX = WIDE_W'(131071);
  localparam logic signed [WIDE_W-1:0] OFFSET_MIN = -WIDE_W'(131072);

  localparam logic [IDX_W-1:0] CFG_SAMPLE_RATE = 3'd0;
  localparam logic [IDX_W-1:0] CFG_ZOOM        = 3'd1;
  localparam logic [IDX_W-1:0] CFG_BAND_MODE   = 3'd2;
  localparam logic [IDX_W-1:0] CFG_LOW_CUT     = 3'd3;
  localparam logic [IDX_W-1:0] CFG_HIGH_CUT    = 3'd4;
  localparam logic [IDX_W-1:0] CFG_NORMAL_STEP = 3'd5;
  localparam logic [IDX_W-1:0] CFG_ACTIVE_VFO  = 3'd6;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LSB  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_USB  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SYM  = 2'd3;

  typedef struct packed {
    logic [RATE_W-1:0]         sample_rate_hz;
    logic [ZOOM_W-1:0]         zoom_level;
    logic [MODE_W-1:0]         band_mode;
    logic signed [LOCUT_W-1:0] filter_low_cut_hz;
    logic [HICUT_W-1:0]        filter_high_cut_hz;
  } fta_window_cfg_t;

endpackage

// ----- rtl/core/fta_accel.sv -----
// Knob acceleration tracker: event gap, short-gap count and fast-tune flag.
// Depends on fta_pkg.
module fta_accel (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [fta_pkg::TIME_W-1:0]  event_time,
  output logic                        fast_now
);

  logic [fta_pkg::TIME_W-1:0] last_time;
  logic [fta_pkg::CNT_W-1:0]  count;
  logic                       fast_on;
  logic [fta_pkg::CNT_W-1:0]  count_next;
  logic [fta_pkg::CNT_W-1:0]  count_inc;
  logic                       fast_on_next;
  logic [fta_pkg::TIME_W-1:0] gap;

  always_comb begin
    gap          = event_time - last_time;
    count_next   = count;
    fast_on_next = fast_on;
    count_inc    = count;
    if (fast_on) begin
      if (gap >= fta_pkg::FAST_CANCEL_MS) begin
        fast_on_next = 1'b0;
      end
    end else begin
      if (gap <= fta_pkg::FAST_GAP_MS) begin
        count_inc = count + fta_pkg::CNT_W'(1);
      end
      if (count_inc >= fta_pkg::FAST_TRIGGER) begin
        count_next   = '0;
        fast_on_next = 1'b1;
      end else begin
        count_next = count_inc;
      end
    end
  end

  assign fast_now = fast_on_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
      count     <= '0;
      fast_on   <= 1'b0;
    end else if (advance) begin
      last_time <= event_time;
      count     <= count_next;
      fast_on   <= fast_on_next;
    end
  end

endmodule

// ----- rtl/core/fta_clamp.sv -----
// Offset update: step times knob delta added to the stored offset, then clamped
// to the visible window narrowed by the filter edges. Depends on fta_pkg.
module fta_clamp (
  input  fta_pkg::fta_window_cfg_t            win,
  input  logic [fta_pkg::STEP_W-1:0]          step,
  input  logic signed [fta_pkg::DELTA_W-1:0]  delta,
  input  logic signed [fta_pkg::OFF_W-1:0]    stored,
  output logic signed [fta_pkg::OFF_W-1:0]    offset
);

  logic signed [fta_pkg::PROD_W-1:0]  prod;
  logic signed [fta_pkg::STEP_W:0]    step_s;
  logic [fta_pkg::RATE_W-1:0]         shifted;
  logic [fta_pkg::RATE_W-2:0]         half;
  logic [fta_pkg::LOCUT_W:0]          low_abs;
  logic [fta_pkg::LOCUT_W:0]          edge_hz;
  logic signed [fta_pkg::WIDE_W-1:0]  lower;
  logic signed [fta_pkg::WIDE_W-1:0]  upper;
  logic signed [fta_pkg::WIDE_W-1:0]  low_w;
  logic signed [fta_pkg::WIDE_W-1:0]  high_w;
  logic signed [fta_pkg::WIDE_W-1:0]  off1;
  logic signed [fta_pkg::WIDE_W-1:0]  off2;
  logic signed [fta_pkg::WIDE_W-1:0]  off3;

  always_comb begin
    step_s  = $signed({1'b0, step});
    prod    = fta_pkg::PROD_W'(step_s) * fta_pkg::PROD_W'(delta);
    off1    = fta_pkg::WIDE_W'(stored) + fta_pkg::WIDE_W'(prod);

    shifted = win.sample_rate_hz >> win.zoom_level;
    half    = shifted[fta_pkg::RATE_W-1:1];
    low_w   = fta_pkg::WIDE_W'(win.filter_low_cut_hz);
    high_w  = $signed({{(fta_pkg::WIDE_W-fta_pkg::HICUT_W){1'b0}}, win.filter_high_cut_hz});
    low_abs = win.filter_low_cut_hz[fta_pkg::LOCUT_W-1]
              ? fta_pkg::LOCUT_W'(1) + fta_pkg::LOCUT_W'(~win.filter_low_cut_hz)
                + (fta_pkg::LOCUT_W+1)'(0)
              : (fta_pkg::LOCUT_W+1)'(win.filter_low_cut_hz);
    if (win.filter_low_cut_hz[fta_pkg::LOCUT_W-1]) begin
      low_abs = (fta_pkg::LOCUT_W+1)'(0) - {1'b1, win.filter_low_cut_hz};
    end
    edge_hz = ((fta_pkg::LOCUT_W+1)'(win.filter_high_cut_hz) > low_abs)
              ? (fta_pkg::LOCUT_W+1)'(win.filter_high_cut_hz) : low_abs;

    upper = $signed({{(fta_pkg::WIDE_W-fta_pkg::RATE_W+1){1'b0}}, half});
    lower = -upper;
    case (win.band_mode)
      fta_pkg::MODE_LSB: begin
        lower = lower - low_w;
      end
      fta_pkg::MODE_USB: begin
        upper = upper - high_w;
      end
      fta_pkg::MODE_SYM: begin
        lower = lower + $signed({{(fta_pkg::WIDE_W-fta_pkg::LOCUT_W-1){1'b0}}, edge_hz});
        upper = upper - $signed({{(fta_pkg::WIDE_W-fta_pkg::LOCUT_W-1){1'b0}}, edge_hz});
      end
      default: begin
      end
    endcase

    off2 = ((-off1) > upper) ? -upper : off1;
    off3 = ((-off2) < lower) ? -lower : off2;
    if (off3 > fta_pkg::OFFSET_MAX) begin
      off3 = fta_pkg::OFFSET_MAX;
    end
    if (off3 < fta_pkg::OFFSET_MIN) begin
      off3 = fta_pkg::OFFSET_MIN;
    end
    offset = off3[fta_pkg::OFF_W-1:0];
  end

endmodule

// ----- rtl/core/fine_tune_accel_clamp.sv -----
// Fine-tune offset with knob acceleration and window clamp: top level.
// Instantiates fta_accel and fta_clamp; depends on fta_pkg.
//
// Each knob word (signed step count and millisecond timestamp) is held in an
// input register, then the acceleration state, the per-VFO offset and the
// clamp are evaluated and the result word lands in an output register.
// One word per cycle is taken in steady state while the output is not stalled;
// out_valid rises as the word moves from the input register into the output
// register, and an output stall holds it in the input register. The offset store
// and acceleration state are updated as a word moves into the output register,
// so the next word sees them at once. Configuration is written through
// cfg_write_en / cfg_index / cfg_data; the user must do so only while the
// block is idle (not enforced); indexes beyond the register list are ignored.
module fine_tune_accel_clamp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [fta_pkg::IDX_W-1:0]           cfg_index,
  input  logic [fta_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [fta_pkg::DELTA_W-1:0]  encoder_delta,
  input  logic [fta_pkg::TIME_W-1:0]          time_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fta_pkg::OFF_W-1:0]    fine_tune_hz,
  output logic                                fast_tune_active
);

  fta_pkg::fta_window_cfg_t            win;
  logic [fta_pkg::STEP_W-1:0]          normal_step;
  logic                                active_vfo;

  logic                                s1_valid;
  logic signed [fta_pkg::DELTA_W-1:0]  s1_delta;
  logic [fta_pkg::TIME_W-1:0]          s1_time;
  logic                                advance;
  logic                                in_take;

  logic signed [fta_pkg::OFF_W-1:0]    store [fta_pkg::NUM_VFOS];
  logic [fta_pkg::VFO_W-1:0]           vfo;
  logic                                fast_now;
  logic [fta_pkg::STEP_W-1:0]          step;
  logic signed [fta_pkg::OFF_W-1:0]    offset_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.sample_rate_hz     <= fta_pkg::RATE_W'(192000);
      win.zoom_level         <= '0;
      win.band_mode          <= fta_pkg::MODE_NONE;
      win.filter_low_cut_hz  <= '0;
      win.filter_high_cut_hz <= '0;
      normal_step            <= fta_pkg::STEP_W'(10);
      active_vfo             <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        fta_pkg::CFG_SAMPLE_RATE: win.sample_rate_hz     <= cfg_data[fta_pkg::RATE_W-1:0];
        fta_pkg::CFG_ZOOM:        win.zoom_level         <= cfg_data[fta_pkg::ZOOM_W-1:0];
        fta_pkg::CFG_BAND_MODE:   win.band_mode          <= cfg_data[fta_pkg::MODE_W-1:0];
        fta_pkg::CFG_LOW_CUT:     win.filter_low_cut_hz  <= cfg_data[fta_pkg::LOCUT_W-1:0];
        fta_pkg::CFG_HIGH_CUT:    win.filter_high_cut_hz <= cfg_data[fta_pkg::HICUT_W-1:0];
        fta_pkg::CFG_NORMAL_STEP: normal_step            <= cfg_data[fta_pkg::STEP_W-1:0];
        fta_pkg::CFG_ACTIVE_VFO:  active_vfo             <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_delta <= encoder_delta;
      s1_time  <= time_ms;
    end
  end

  always_comb begin
    if (32'(active_vfo) < 32'(fta_pkg::NUM_VFOS)) begin
      vfo = fta_pkg::VFO_W'(active_vfo);
    end else begin
      vfo = fta_pkg::VFO_W'(fta_pkg::NUM_VFOS - 1);
    end
  end

  fta_accel u_accel (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .event_time (s1_time),
    .fast_now   (fast_now)
  );

  assign step = fast_now ? fta_pkg::FAST_STEP_HZ : normal_step;

  fta_clamp u_clamp (
    .win    (win),
    .step   (step),
    .delta  (s1_delta),
    .stored (store[vfo]),
    .offset (offset_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fta_pkg::NUM_VFOS; i++) begin
        store[i] <= '0;
      end
    end else if (advance) begin
      store[vfo] <= offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fine_tune_hz     <= offset_next;
      fast_tune_active <= fast_now;
    end
  end

endmodule

// ----- test/fine_tune_accel_clamp_test.sv -----
`timescale 1ns / 100ps
// Testbench for fine_tune_accel_clamp: knob words are sent and each result word is
// compared with a local predictor of the offset, acceleration and window clamp.
// Depends on fta_pkg and the fine_tune_accel_clamp RTL.
module fine_tune_accel_clamp_test;

  localparam logic [fta_pkg::IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam int STUCK_LIMIT = 1000;

  typedef struct packed {
    logic signed [fta_pkg::OFF_W-1:0] hz;
    logic                             fast;
  } tune_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [fta_pkg::IDX_W-1:0] cfg_index = '0;
  logic [fta_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [fta_pkg::DELTA_W-1:0] encoder_delta = '0;
  logic [fta_pkg::TIME_W-1:0] time_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [fta_pkg::OFF_W-1:0] fine_tune_hz;
  logic fast_tune_active;

  // predictor state and its copy of the registers
  logic signed [fta_pkg::OFF_W-1:0] vfo_offset [fta_pkg::NUM_VFOS] = '{default: '0};
  logic [fta_pkg::TIME_W-1:0] last_stamp = '0;
  logic [fta_pkg::CNT_W-1:0] short_gaps = '0;
  logic fast_mode = 1'b0;
  logic [fta_pkg::RATE_W-1:0] rate_hz = fta_pkg::RATE_W'(192000);
  logic [fta_pkg::ZOOM_W-1:0] zoom = '0;
  logic [fta_pkg::MODE_W-1:0] band = fta_pkg::MODE_NONE;
  logic signed [fta_pkg::LOCUT_W-1:0] lo_cut = '0;
  logic [fta_pkg::HICUT_W-1:0] hi_cut = '0;
  logic [fta_pkg::STEP_W-1:0] norm_step = fta_pkg::STEP_W'(10);
  logic vfo_sel = 1'b0;

  tune_word_t expected_tune [$];
  logic [fta_pkg::TIME_W-1:0] now_ms = '0;
  logic calm = 1'b0;
  int errors = 0;
  int stuck_cycles = 0;
  int stall_left = 0;

  fine_tune_accel_clamp DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .encoder_delta(encoder_delta),
    .time_ms(time_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .fine_tune_hz(fine_tune_hz),
    .fast_tune_active(fast_tune_active)
  );

  always #5 clk = ~clk;

  function automatic void predict_knob(logic signed [fta_pkg::DELTA_W-1:0] delta,
                                       logic [fta_pkg::TIME_W-1:0] stamp);
    logic [fta_pkg::TIME_W-1:0] gap;
    int unsigned slot;
    longint step_hz, sum, half, lo_lim, hi_lim, margin, lo_mag;
    tune_word_t want;
    gap = stamp - last_stamp;
    last_stamp = stamp;
    if (fast_mode) begin
      if (gap >= fta_pkg::FAST_CANCEL_MS) fast_mode = 1'b0;
    end else begin
      if (gap <= fta_pkg::FAST_GAP_MS) short_gaps = short_gaps + 1'b1;
      if (short_gaps >= fta_pkg::FAST_TRIGGER) begin
        short_gaps = '0;
        fast_mode = 1'b1;
      end
    end
    slot = (vfo_sel < fta_pkg::NUM_VFOS) ? vfo_sel : fta_pkg::NUM_VFOS - 1;
    step_hz = fast_mode ? longint'(fta_pkg::FAST_STEP_HZ) : longint'(norm_step);
    sum = longint'(vfo_offset[slot]) + step_hz * longint'(delta);
    half = longint'((rate_hz >> zoom) >> 1);
    lo_lim = -half;
    hi_lim = half;
    lo_mag = longint'(lo_cut);
    if (lo_mag < 0) lo_mag = -lo_mag;
    margin = longint'(hi_cut);
    if (lo_mag > margin) margin = lo_mag;
    case (band)
      fta_pkg::MODE_LSB: lo_lim = lo_lim - longint'(lo_cut);
      fta_pkg::MODE_USB: hi_lim = hi_lim - longint'(hi_cut);
      fta_pkg::MODE_SYM: begin
        lo_lim = lo_lim + margin;
        hi_lim = hi_lim - margin;
      end
      default: ;
    endcase
    if (-sum > hi_lim) sum = -hi_lim;
    if (-sum < lo_lim) sum = -lo_lim;
    if (sum > longint'(fta_pkg::OFFSET_MAX)) sum = longint'(fta_pkg::OFFSET_MAX);
    if (sum < longint'(fta_pkg::OFFSET_MIN)) sum = longint'(fta_pkg::OFFSET_MIN);
    vfo_offset[slot] = sum[fta_pkg::OFF_W-1:0];
    want.hz = sum[fta_pkg::OFF_W-1:0];
    want.fast = fast_mode;
    expected_tune.push_back(want);
  endfunction

  task automatic write_reg(input logic [fta_pkg::IDX_W-1:0] idx,
                           input logic [fta_pkg::CFG_W-1:0] data);
    cfg_write_en = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    case (idx)
      fta_pkg::CFG_SAMPLE_RATE: rate_hz = data[fta_pkg::RATE_W-1:0];
      fta_pkg::CFG_ZOOM:        zoom = data[fta_pkg::ZOOM_W-1:0];
      fta_pkg::CFG_BAND_MODE:   band = data[fta_pkg::MODE_W-1:0];
      fta_pkg::CFG_LOW_CUT:     lo_cut = data[fta_pkg::LOCUT_W-1:0];
      fta_pkg::CFG_HIGH_CUT:    hi_cut = data[fta_pkg::HICUT_W-1:0];
      fta_pkg::CFG_NORMAL_STEP: norm_step = data[fta_pkg::STEP_W-1:0];
      fta_pkg::CFG_ACTIVE_VFO:  vfo_sel = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [fta_pkg::RATE_W-1:0] rate,
                            input logic [fta_pkg::ZOOM_W-1:0] zm,
                            input logic [fta_pkg::MODE_W-1:0] mode,
                            input logic signed [fta_pkg::LOCUT_W-1:0] lo,
                            input logic [fta_pkg::HICUT_W-1:0] hi,
                            input logic [fta_pkg::STEP_W-1:0] step,
                            input logic vfo);
    write_reg(fta_pkg::CFG_SAMPLE_RATE, fta_pkg::CFG_W'(rate));
    write_reg(fta_pkg::CFG_ZOOM, fta_pkg::CFG_W'(zm));
    write_reg(fta_pkg::CFG_BAND_MODE, fta_pkg::CFG_W'(mode));
    write_reg(fta_pkg::CFG_LOW_CUT, fta_pkg::CFG_W'(lo));
    write_reg(fta_pkg::CFG_HIGH_CUT, fta_pkg::CFG_W'(hi));
    write_reg(fta_pkg::CFG_NORMAL_STEP, fta_pkg::CFG_W'(step));
    write_reg(fta_pkg::CFG_ACTIVE_VFO, fta_pkg::CFG_W'(vfo));
    write_reg(CFG_SPARE, fta_pkg::CFG_W'($urandom));
    cfg_write_en = 1'b0;
  endtask

  task automatic send_knob(input logic signed [fta_pkg::DELTA_W-1:0] delta,
                           input logic [fta_pkg::TIME_W-1:0] stamp);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    encoder_delta = delta;
    time_ms = stamp;
    in_valid = 1'b1;
    now_ms = stamp;
    do @(posedge clk); while (in_stall);
    predict_knob(delta, stamp);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (expected_tune.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_reset_state();
    send_knob(8'sd127, 32'd40);
    send_knob(-8'sd128, 32'd1040);
    send_knob(8'sd0, 32'd2040);
    drain();
  endtask

  // short gaps accumulate across a long one, then fast tune holds below 500 ms
  task automatic test_fast_tune();
    set_config(fta_pkg::RATE_W'(192000), 3'd0, fta_pkg::MODE_NONE, 16'sd0, 15'd0,
               fta_pkg::STEP_W'(100), 1'b0);
    send_knob(8'sd1, 32'd3000);
    send_knob(8'sd1, 32'd3050);
    send_knob(8'sd1, 32'd3100);
    send_knob(8'sd1, 32'd3150);
    send_knob(-8'sd1, 32'd3649);
    send_knob(8'sd1, 32'd4149);
    send_knob(8'sd5, 32'hFFFF_FFC0);
    send_knob(-8'sd5, 32'h0000_0010);
    drain();
  endtask

  task automatic test_window_limits();
    set_config(fta_pkg::RATE_W'(192000), 3'd0, fta_pkg::MODE_NONE, 16'sd0, 15'd0,
               fta_pkg::STEP_W'(100000), 1'b0);
    send_knob(8'sd127, 32'd5000);
    send_knob(-8'sd128, 32'd6000);
    drain();
    // crossed limits
    set_config(fta_pkg::RATE_W'(8000), 3'd0, fta_pkg::MODE_LSB, -16'sd20000, 15'd0,
               fta_pkg::STEP_W'(1), 1'b0);
    send_knob(8'sd0, 32'd7000);
    drain();
    set_config(fta_pkg::RATE_W'(192000), 3'd7, fta_pkg::MODE_USB, 16'sd0, 15'd20000,
               fta_pkg::STEP_W'(1), 1'b0);
    send_knob(8'sd3, 32'd8000);
    drain();
    set_config(fta_pkg::RATE_W'(192000), 3'd1, fta_pkg::MODE_SYM, -16'sd300, 15'd20000,
               fta_pkg::STEP_W'(1), 1'b0);
    send_knob(-8'sd1, 32'd9000);
    drain();
    set_config(fta_pkg::RATE_W'(192000), 3'd1, fta_pkg::MODE_SYM, -16'sd20000, 15'd100,
               fta_pkg::STEP_W'(1), 1'b0);
    send_knob(8'sd1, 32'd10000);
    drain();
    // out-of-range cutoff lets the sum pass the offset width
    set_config(fta_pkg::RATE_W'(262143), 3'd0, fta_pkg::MODE_LSB, 16'sd32767, 15'd0,
               fta_pkg::STEP_W'(100000), 1'b0);
    send_knob(8'sd127, 32'd11000);
    send_knob(8'sd127, 32'd12000);
    drain();
    set_config(fta_pkg::RATE_W'(192000), 3'd0, fta_pkg::MODE_NONE, 16'sd0, 15'd0,
               fta_pkg::STEP_W'(100000), 1'b1);
    send_knob(-8'sd128, 32'd13000);
    send_knob(-8'sd128, 32'd13050);
    drain();
    set_config(fta_pkg::RATE_W'(192000), 3'd0, fta_pkg::MODE_NONE, 16'sd0, 15'd0,
               fta_pkg::STEP_W'(1), 1'b0);
    send_knob(8'sd0, 32'd14000);
    drain();
  endtask

  task automatic random_config();
    logic [fta_pkg::RATE_W-1:0] rate;
    logic signed [fta_pkg::LOCUT_W-1:0] lo;
    logic [fta_pkg::HICUT_W-1:0] hi;
    logic [fta_pkg::STEP_W-1:0] step;
    rate = ($urandom_range(0, 4) == 0) ? fta_pkg::RATE_W'($urandom)
                                       : fta_pkg::RATE_W'($urandom_range(8000, 192000));
    lo = ($urandom_range(0, 4) == 0) ? fta_pkg::LOCUT_W'($urandom)
                                     : -fta_pkg::LOCUT_W'($urandom_range(0, 20000));
    hi = ($urandom_range(0, 4) == 0) ? fta_pkg::HICUT_W'($urandom)
                                     : fta_pkg::HICUT_W'($urandom_range(0, 20000));
    case ($urandom_range(0, 4))
      0: step = fta_pkg::STEP_W'($urandom);
      1: step = fta_pkg::STEP_W'($urandom_range(1, 100000));
      default: step = fta_pkg::STEP_W'($urandom_range(1, 1000));
    endcase
    set_config(rate, fta_pkg::ZOOM_W'($urandom), fta_pkg::MODE_W'($urandom), lo, hi, step,
               1'($urandom));
  endtask

  task automatic test_random_traffic();
    int seg;
    int n;
    int pick;
    logic signed [fta_pkg::DELTA_W-1:0] delta;
    logic [fta_pkg::TIME_W-1:0] stamp;
    for (seg = 0; seg < 12; seg++) begin
      calm = (seg >= 10) || ($urandom_range(0, 3) == 0);
      random_config();
      for (n = 0; n < 100; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) stamp = now_ms + $urandom_range(0, 100);
        else if (pick < 80) stamp = now_ms + $urandom_range(101, 499);
        else if (pick < 95) stamp = now_ms + $urandom_range(500, 5000);
        else stamp = $urandom;
        if ($urandom_range(0, 1) == 0) delta = fta_pkg::DELTA_W'($urandom_range(0, 8)) - 8'sd4;
        else delta = fta_pkg::DELTA_W'($urandom);
        send_knob(delta, stamp);
      end
      drain();
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
      if (!calm && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 12);
    end
  end

  always @(posedge clk) begin : check_words
    tune_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_tune.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual hz=%0d fast=%0b",
                 $time, fine_tune_hz, fast_tune_active);
      end else begin
        want = expected_tune.pop_front();
        if (fine_tune_hz !== want.hz) begin
          errors++;
          $display("%0t: fine_tune_hz expected %0d actual %0d", $time, want.hz, fine_tune_hz);
        end
        if (fast_tune_active !== want.fast) begin
          errors++;
          $display("%0t: fast_tune_active expected %0b actual %0b",
                   $time, want.fast, fast_tune_active);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;
    test_reset_state();
    test_fast_tune();
    test_window_limits();
    test_random_traffic();
    if (errors == 0 && expected_tune.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/fta_pkg.sv
rtl/core/fta_accel.sv
rtl/core/fta_clamp.sv
rtl/core/fine_tune_accel_clamp.sv
test/fine_tune_accel_clamp_test.sv
